// ===== rtl/mandelbrot_escape_time_assert.svh =====
// Assertion macros shared by the checker of the Mandelbrot escape-time block
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define MBE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define MBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mbe_pkg.sv =====
// Types, widths and constants of the Mandelbrot escape-time block
package mbe_pkg;

  // Image and fixed-point format
  localparam int IMAGE_DIM = 8192;
  localparam int IDX_W     = $clog2(IMAGE_DIM);
  localparam int FRAC_BITS = 28;
  localparam int COORD_W   = 32;
  localparam int STEP_W    = 31;
  localparam int ITER_W    = 16;

  // Point c: min + idx*step, signed
  localparam int PROD_W = IDX_W + STEP_W;
  localparam int C_W    = PROD_W + 2;
  // Iterate z: c plus a term below 2^31 in magnitude
  localparam int Z_W    = C_W + 1;
  // z with |z| < 2^(FRAC_BITS+1) fits this signed width
  localparam int ZS_W   = FRAC_BITS + 2;
  // Square of such a z; bit SQ_W of a sum of squares is the escape test
  localparam int SQ_W   = 2 * FRAC_BITS + 2;

  // Work queue between front and core
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register map
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_RE_MIN     = 2'd0,
    REG_IM_MIN     = 2'd1,
    REG_PIXEL_STEP = 2'd2,
    REG_MAX_ITER   = 2'd3
  } reg_idx_t;

  localparam logic [COORD_W-1:0] RE_MIN_RST     = 32'hD800_0000;
  localparam logic [COORD_W-1:0] IM_MIN_RST     = 32'hE000_0000;
  localparam logic [STEP_W-1:0]  PIXEL_STEP_RST = 31'd167772;
  localparam logic [ITER_W-1:0]  MAX_ITER_RST   = 16'd200;

  // One pixel job handed from front to core
  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic [C_W-1:0]   c_re;
    logic [C_W-1:0]   c_im;
  } job_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MUL,
    FS_ADD,
    FS_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_MUL,
    CS_UPD,
    CS_DONE
  } core_state_t;

endpackage

// ===== rtl/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time unit. Each input word (col, row) names one pixel; the
// front end forms c = (re_min + col*pixel_step, im_min + row*pixel_step) in
// signed Q4.28 and passes it through a two-entry queue to the iteration core.
// Each iteration of the core has a multiply step (the three 30x30 products) and
// an update step (the escape test and the update of z). A pixel stops after the
// multiply step when it reaches the limit or when one coordinate of z already
// reaches 2, and after the update step when only the sum of squares reaches 4;
// points inside stop on the limit. A finished result may wait on out_stall.
// The core iteration loop sets the throughput.
// One result word per input word, in order.
// Registers (APB, 32-bit): 0x0 re_min, 0x4 im_min, 0x8 pixel_step, 0xC
// max_iter; write them only while no pixel is in flight.
module mandelbrot_escape_time (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbe_pkg::PADDR_W-1:0]  paddr,
  input  logic [mbe_pkg::PDATA_W-1:0]  pwdata,
  output logic [mbe_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  // pixel input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mbe_pkg::IDX_W-1:0]    col,
  input  logic [mbe_pkg::IDX_W-1:0]    row,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mbe_pkg::IDX_W-1:0]    col_out,
  output logic [mbe_pkg::IDX_W-1:0]    row_out,
  output logic [mbe_pkg::ITER_W-1:0]   iterations,
  output logic                         inside_res
);

  logic [mbe_pkg::COORD_W-1:0] re_min, im_min;
  logic [mbe_pkg::STEP_W-1:0]  pixel_step;
  logic [mbe_pkg::ITER_W-1:0]  max_iter;
  mbe_pkg::reg_idx_t           reg_idx;
  logic                        reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = mbe_pkg::reg_idx_t'(paddr[mbe_pkg::PADDR_W-1:2]);
  assign reg_wr  = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      re_min     <= mbe_pkg::RE_MIN_RST;
      im_min     <= mbe_pkg::IM_MIN_RST;
      pixel_step <= mbe_pkg::PIXEL_STEP_RST;
      max_iter   <= mbe_pkg::MAX_ITER_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        mbe_pkg::REG_RE_MIN:     re_min     <= pwdata;
        mbe_pkg::REG_IM_MIN:     im_min     <= pwdata;
        mbe_pkg::REG_PIXEL_STEP: pixel_step <= pwdata[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_MAX_ITER:   max_iter   <= pwdata[mbe_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      mbe_pkg::REG_RE_MIN:     prdata = re_min;
      mbe_pkg::REG_IM_MIN:     prdata = im_min;
      mbe_pkg::REG_PIXEL_STEP: prdata = {{(mbe_pkg::PDATA_W - mbe_pkg::STEP_W){1'b0}},
                                         pixel_step};
      mbe_pkg::REG_MAX_ITER:   prdata = {{(mbe_pkg::PDATA_W - mbe_pkg::ITER_W){1'b0}},
                                         max_iter};
      default:                 prdata = '0;
    endcase
  end

  logic          push_valid, push_ready, job_valid, job_pop;
  mbe_pkg::job_t push_job, job;

  mbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .re_min     (re_min),
    .im_min     (im_min),
    .pixel_step (pixel_step),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .col        (col),
    .row        (row),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  mbe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (job_valid),
    .pop_ready  (job_pop),
    .pop_job    (job)
  );

  mbe_core u_core (
    .clk        (clk),
    .rst        (rst),
    .max_iter   (max_iter),
    .job_valid  (job_valid),
    .job_pop    (job_pop),
    .job        (job),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .col_out    (col_out),
    .row_out    (row_out),
    .iterations (iterations),
    .inside_res (inside_res)
  );

endmodule

// ===== rtl/mbe_front.sv =====
// Front end: takes a pixel word and forms the point c in fixed point
module mbe_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mbe_pkg::COORD_W-1:0] re_min,
  input  logic [mbe_pkg::COORD_W-1:0] im_min,
  input  logic [mbe_pkg::STEP_W-1:0]  pixel_step,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mbe_pkg::IDX_W-1:0]   col,
  input  logic [mbe_pkg::IDX_W-1:0]   row,
  output logic                        push_valid,
  input  logic                        push_ready,
  output mbe_pkg::job_t               push_job
);

  mbe_pkg::front_state_t state, state_next;

  logic [mbe_pkg::IDX_W-1:0]  col_q, row_q;
  logic [mbe_pkg::PROD_W-1:0] prod_re, prod_im;
  logic [mbe_pkg::C_W-1:0]    c_re, c_im;
  logic                       accept;

  // Snap test: c_im forced to zero when 2*|c_im| < step
  logic signed [mbe_pkg::C_W:0] twice_im, step_ext;
  logic                         snap;

  assign twice_im = {c_im, 1'b0};
  assign step_ext = {{(mbe_pkg::C_W + 1 - mbe_pkg::STEP_W){1'b0}}, pixel_step};
  assign snap     = (twice_im < step_ext) && (twice_im > -step_ext);

  assign push_job.col  = col_q;
  assign push_job.row  = row_q;
  assign push_job.c_re = c_re;
  assign push_job.c_im = snap ? '0 : c_im;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbe_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    push_valid = 1'b0;
    accept     = 1'b0;
    unique case (state)
      mbe_pkg::FS_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) begin
          state_next = mbe_pkg::FS_MUL;
        end
      end
      mbe_pkg::FS_MUL: state_next = mbe_pkg::FS_ADD;
      mbe_pkg::FS_ADD: state_next = mbe_pkg::FS_PUSH;
      mbe_pkg::FS_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_next = mbe_pkg::FS_IDLE;
        end
      end
      default: state_next = mbe_pkg::FS_IDLE;
    endcase
  end

  // Datapath: capture, scale by step, offset by origin
  always_ff @(posedge clk) begin
    if (accept) begin
      col_q <= col;
      row_q <= row;
    end
    if (state == mbe_pkg::FS_MUL) begin
      prod_re <= {{mbe_pkg::STEP_W{1'b0}}, col_q} * {{mbe_pkg::IDX_W{1'b0}}, pixel_step};
      prod_im <= {{mbe_pkg::STEP_W{1'b0}}, row_q} * {{mbe_pkg::IDX_W{1'b0}}, pixel_step};
    end
    if (state == mbe_pkg::FS_ADD) begin
      c_re <= {{(mbe_pkg::C_W - mbe_pkg::COORD_W){re_min[mbe_pkg::COORD_W-1]}}, re_min}
            + {2'b00, prod_re};
      c_im <= {{(mbe_pkg::C_W - mbe_pkg::COORD_W){im_min[mbe_pkg::COORD_W-1]}}, im_min}
            + {2'b00, prod_im};
    end
  end

endmodule

// ===== rtl/mbe_queue.sv =====
// Short job queue between front end and iteration core
module mbe_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  mbe_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mbe_pkg::job_t pop_job
);

  mbe_pkg::job_t               entries [mbe_pkg::QUEUE_DEPTH];
  logic [mbe_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [mbe_pkg::QCNT_W-1:0]  count;
  logic                        push, pop;

  assign push_ready = (count != mbe_pkg::QCNT_W'(mbe_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_ready && pop_valid;
  assign pop_job    = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/mbe_core.sv =====
// Iteration core: z = z^2 + c, a multiply step and an update step per iteration, with result register
module mbe_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mbe_pkg::ITER_W-1:0] max_iter,
  input  logic                       job_valid,
  output logic                       job_pop,
  input  mbe_pkg::job_t              job,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mbe_pkg::IDX_W-1:0]  col_out,
  output logic [mbe_pkg::IDX_W-1:0]  row_out,
  output logic [mbe_pkg::ITER_W-1:0] iterations,
  output logic                       inside_res
);

  localparam int F = mbe_pkg::FRAC_BITS;

  mbe_pkg::core_state_t state, state_next;

  logic [mbe_pkg::IDX_W-1:0]  col_q, row_q;
  logic [mbe_pkg::C_W-1:0]    c_re, c_im;
  logic [mbe_pkg::Z_W-1:0]    zx, zy;
  logic [mbe_pkg::ITER_W-1:0] n;
  logic                       load_res;

  // Narrow copies of z; valid when |z| < 2^(F+1)
  logic signed [mbe_pkg::ZS_W-1:0] zx_s, zy_s;
  logic                            x_small, y_small;

  assign zx_s = zx[mbe_pkg::ZS_W-1:0];
  assign zy_s = zy[mbe_pkg::ZS_W-1:0];
  assign x_small = (zx == {{(mbe_pkg::Z_W - mbe_pkg::ZS_W){zx_s[mbe_pkg::ZS_W-1]}}, zx_s})
                && (zx_s != {1'b1, {(mbe_pkg::ZS_W - 1){1'b0}}});
  assign y_small = (zy == {{(mbe_pkg::Z_W - mbe_pkg::ZS_W){zy_s[mbe_pkg::ZS_W-1]}}, zy_s})
                && (zy_s != {1'b1, {(mbe_pkg::ZS_W - 1){1'b0}}});

  // Products
  logic signed [2*mbe_pkg::ZS_W-1:0] p_xx, p_yy, p_xy;
  logic [mbe_pkg::SQ_W-1:0]          x2, y2;
  logic signed [mbe_pkg::SQ_W:0]     xy;

  assign p_xx = zx_s * zx_s;
  assign p_yy = zy_s * zy_s;
  assign p_xy = zx_s * zy_s;

  // Escape test and new z; arithmetic shifts give floor division
  logic [mbe_pkg::SQ_W:0]        mag2;
  logic signed [mbe_pkg::SQ_W:0] diff;
  logic                          escape;
  logic [mbe_pkg::Z_W-1:0]       zx_new, zy_new;

  assign mag2   = {1'b0, x2} + {1'b0, y2};
  assign escape = mag2[mbe_pkg::SQ_W];
  assign diff   = $signed({1'b0, x2}) - $signed({1'b0, y2});
  assign zx_new = {{(mbe_pkg::Z_W - (mbe_pkg::SQ_W + 1 - F)){diff[mbe_pkg::SQ_W]}},
                   diff[mbe_pkg::SQ_W:F]}
                + {c_re[mbe_pkg::C_W-1], c_re};
  assign zy_new = {{(mbe_pkg::Z_W - (mbe_pkg::SQ_W + 2 - F)){xy[mbe_pkg::SQ_W]}},
                   xy[mbe_pkg::SQ_W:F-1]}
                + {c_im[mbe_pkg::C_W-1], c_im};

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbe_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, queue pop, result load
  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    load_res   = 1'b0;
    unique case (state)
      mbe_pkg::CS_IDLE: begin
        job_pop = job_valid;
        if (job_valid) begin
          state_next = mbe_pkg::CS_MUL;
        end
      end
      mbe_pkg::CS_MUL: begin
        if ((n == max_iter) || !x_small || !y_small) begin
          state_next = mbe_pkg::CS_DONE;
        end else begin
          state_next = mbe_pkg::CS_UPD;
        end
      end
      mbe_pkg::CS_UPD: begin
        state_next = escape ? mbe_pkg::CS_DONE : mbe_pkg::CS_MUL;
      end
      mbe_pkg::CS_DONE: begin
        if (!out_valid || !out_stall) begin
          load_res   = 1'b1;
          state_next = mbe_pkg::CS_IDLE;
        end
      end
      default: state_next = mbe_pkg::CS_IDLE;
    endcase
  end

  // Iteration datapath
  always_ff @(posedge clk) begin
    unique case (state)
      mbe_pkg::CS_IDLE: begin
        if (job_valid) begin
          col_q <= job.col;
          row_q <= job.row;
          c_re  <= job.c_re;
          c_im  <= job.c_im;
          zx    <= '0;
          zy    <= '0;
          n     <= '0;
        end
      end
      mbe_pkg::CS_MUL: begin
        x2 <= p_xx[mbe_pkg::SQ_W-1:0];
        y2 <= p_yy[mbe_pkg::SQ_W-1:0];
        xy <= p_xy[mbe_pkg::SQ_W:0];
      end
      mbe_pkg::CS_UPD: begin
        if (!escape) begin
          zx <= zx_new;
          zy <= zy_new;
          n  <= n + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      col_out    <= col_q;
      row_out    <= row_q;
      iterations <= n;
      inside_res <= (n == max_iter);
    end
  end

endmodule

// ===== rtl/mbe_checker.sv =====
// Port-level checker for the Mandelbrot escape-time block, with its bind
`include "mandelbrot_escape_time_assert.svh"

module mbe_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [mbe_pkg::PADDR_W-1:0] paddr,
  input logic [mbe_pkg::PDATA_W-1:0] pwdata,
  input logic                        pready,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [mbe_pkg::IDX_W-1:0]   col_out,
  input logic [mbe_pkg::IDX_W-1:0]   row_out,
  input logic [mbe_pkg::ITER_W-1:0]  iterations,
  input logic                        inside_res
);

  logic [3:0]                 pending;
  logic [mbe_pkg::ITER_W-1:0] max_sh;
  logic                       in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Words accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 1'b1;
    end
  end

  // Shadow of the iteration limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_sh <= mbe_pkg::MAX_ITER_RST;
    end else if (psel && penable && pwrite && pready
                 && (mbe_pkg::reg_idx_t'(paddr[mbe_pkg::PADDR_W-1:2])
                     == mbe_pkg::REG_MAX_ITER)) begin
      max_sh <= pwdata[mbe_pkg::ITER_W-1:0];
    end
  end

  `MBE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(col_out) && $stable(row_out) && $stable(iterations) && $stable(inside_res), "result word changed while stalled")
  `MBE_ASSERT_NOW(a_no_orphan, clk, rst, out_valid, pending != 4'd0, "result word with no pixel pending")
  `MBE_ASSERT_NOW(a_iter_limit, clk, rst, out_valid, (iterations <= max_sh) && (inside_res == (iterations == max_sh)), "iteration count disagrees with limit")

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
  .clk        (clk),
  .rst        (rst),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .pready     (pready),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .col_out    (col_out),
  .row_out    (row_out),
  .iterations (iterations),
  .inside_res (inside_res)
);

// ===== bench/tb_mandelbrot_escape_time.sv =====
// Self-checking testbench for the Mandelbrot escape-time unit
module tb_mandelbrot_escape_time;

  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int DRAIN_CYCLES   = 16;

  typedef struct {
    logic [mbe_pkg::IDX_W-1:0]  col;
    logic [mbe_pkg::IDX_W-1:0]  row;
    logic [mbe_pkg::ITER_W-1:0] iters;
    logic                       in_set;
  } pixel_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [mbe_pkg::PADDR_W-1:0]  paddr = '0;
  logic [mbe_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [mbe_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [mbe_pkg::IDX_W-1:0]    col = '0;
  logic [mbe_pkg::IDX_W-1:0]    row = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [mbe_pkg::IDX_W-1:0]    col_out;
  logic [mbe_pkg::IDX_W-1:0]    row_out;
  logic [mbe_pkg::ITER_W-1:0]   iterations;
  logic                         inside_res;

  // Shadow copy of the register file
  logic [mbe_pkg::COORD_W-1:0]  re_min_q = mbe_pkg::RE_MIN_RST;
  logic [mbe_pkg::COORD_W-1:0]  im_min_q = mbe_pkg::IM_MIN_RST;
  logic [mbe_pkg::STEP_W-1:0]   step_q = mbe_pkg::PIXEL_STEP_RST;
  logic [mbe_pkg::ITER_W-1:0]   max_iter_q = mbe_pkg::MAX_ITER_RST;

  pixel_result_t pending_pixels[$];
  int errors = 0;
  int pixels_sent = 0;
  int directed_pixels = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  mandelbrot_escape_time DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .col(col), .row(row),
    .out_valid(out_valid), .out_stall(out_stall), .col_out(col_out),
    .row_out(row_out), .iterations(iterations), .inside_res(inside_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Escape-time count of one pixel under the shadow registers
  function automatic pixel_result_t escape_count(input logic [mbe_pkg::IDX_W-1:0] c_idx,
                                                 input logic [mbe_pkg::IDX_W-1:0] r_idx);
    pixel_result_t res;
    logic signed [127:0] stp, c_re, c_im, mag, zx, zy, x2, y2, xy, lim;
    int n;
    stp  = $signed({97'd0, step_q});
    c_re = $signed({{96{re_min_q[31]}}, re_min_q}) + $signed({115'd0, c_idx}) * stp;
    c_im = $signed({{96{im_min_q[31]}}, im_min_q}) + $signed({115'd0, r_idx}) * stp;
    lim  = 128'sd1 <<< (2 * mbe_pkg::FRAC_BITS + 2);
    mag  = (c_im < 0) ? -c_im : c_im;
    // points within half a step of the real axis sit on it
    if (2 * mag < stp)
      c_im = 0;
    zx = 0;
    zy = 0;
    n  = 0;
    while (n < int'(max_iter_q)) begin
      x2 = zx * zx;
      y2 = zy * zy;
      if (x2 + y2 >= lim)
        break;
      // arithmetic shift rounds toward minus infinity
      xy = zx * zy;
      zy = ((xy + xy) >>> mbe_pkg::FRAC_BITS) + c_im;
      zx = ((x2 - y2) >>> mbe_pkg::FRAC_BITS) + c_re;
      n++;
    end
    res.col    = c_idx;
    res.row    = r_idx;
    res.iters  = n[mbe_pkg::ITER_W-1:0];
    res.in_set = (n == int'(max_iter_q));
    return res;
  endfunction

  function automatic logic [mbe_pkg::PDATA_W-1:0] reg_value(input mbe_pkg::reg_idx_t idx);
    case (idx)
      mbe_pkg::REG_RE_MIN:     return re_min_q;
      mbe_pkg::REG_IM_MIN:     return im_min_q;
      mbe_pkg::REG_PIXEL_STEP: return {1'b0, step_q};
      default:                 return {16'd0, max_iter_q};
    endcase
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Result checker and watchdog
  always @(posedge clk) begin
    pixel_result_t exp_res;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual (%0d,%0d) %0d/%0d",
                   $time, col_out, row_out, iterations, inside_res);
          errors++;
        end else begin
          exp_res = pending_pixels.pop_front();
          check_field("col_out", int'(exp_res.col), int'(col_out));
          check_field("row_out", int'(exp_res.row), int'(row_out));
          check_field("iterations", int'(exp_res.iters), int'(iterations));
          check_field("inside_res", int'(exp_res.in_set), int'(inside_res));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 pending_pixels.size());
        $display("mandelbrot_escape_time test failed");
        $finish;
      end
    end
  end

  // Receiver back-pressure, switching between patterns
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= ((stall_left % 8) < 3);
    endcase
  end

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_xfer(input logic wr, input mbe_pkg::reg_idx_t idx,
                          input logic [mbe_pkg::PDATA_W-1:0] wdata,
                          output logic [mbe_pkg::PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= mbe_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input mbe_pkg::reg_idx_t idx);
    logic [mbe_pkg::PDATA_W-1:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== reg_value(idx)) begin
      $display("%0t: readback of %s, expected %h, actual %h", $time, idx.name(),
               reg_value(idx), rd);
      errors++;
    end
  endtask

  task automatic set_reg(input mbe_pkg::reg_idx_t idx,
                         input logic [mbe_pkg::PDATA_W-1:0] val);
    logic [mbe_pkg::PDATA_W-1:0] rd;
    apb_xfer(1'b1, idx, val, rd);
    case (idx)
      mbe_pkg::REG_RE_MIN:     re_min_q = val;
      mbe_pkg::REG_IM_MIN:     im_min_q = val;
      mbe_pkg::REG_PIXEL_STEP: step_q = val[mbe_pkg::STEP_W-1:0];
      default:                 max_iter_q = val[mbe_pkg::ITER_W-1:0];
    endcase
    reg_writes++;
    check_reg(idx);
  endtask

  task automatic set_window(input logic [31:0] re0, input logic [31:0] im0,
                            input logic [31:0] stp, input logic [31:0] lim);
    set_reg(mbe_pkg::REG_RE_MIN, re0);
    set_reg(mbe_pkg::REG_IM_MIN, im0);
    set_reg(mbe_pkg::REG_PIXEL_STEP, stp);
    set_reg(mbe_pkg::REG_MAX_ITER, lim);
  endtask

  // Send one pixel word; bursts of random length with random gaps
  task automatic send_pixel(input int c_idx, input int r_idx);
    int gap;
    logic [mbe_pkg::IDX_W-1:0] c_w, r_w;
    c_w = mbe_pkg::IDX_W'(c_idx);
    r_w = mbe_pkg::IDX_W'(r_idx);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) == 0)
        gap = 0;
      else if ($urandom_range(0, 7) == 0)
        gap = $urandom_range(20, 300);
      else
        gap = $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    col      <= c_w;
    row      <= r_w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pixels.push_back(escape_count(c_w, r_w));
    pixels_sent++;
    burst_left--;
  endtask

  // Mostly pixels inside a span of the window, some anywhere in the image
  task automatic send_random(input int span);
    if ($urandom_range(0, 99) < 85)
      send_pixel(int'($urandom_range(0, span - 1)), int'($urandom_range(0, span - 1)));
    else
      send_pixel(int'($urandom_range(0, mbe_pkg::IMAGE_DIM - 1)),
                 int'($urandom_range(0, mbe_pkg::IMAGE_DIM - 1)));
  endtask

  // Let every pixel in flight come out so the registers may change
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Reset values, image corners, and the origin (which lands on the real axis)
  task automatic test_reset_values();
    check_reg(mbe_pkg::REG_RE_MIN);
    check_reg(mbe_pkg::REG_IM_MIN);
    check_reg(mbe_pkg::REG_PIXEL_STEP);
    check_reg(mbe_pkg::REG_MAX_ITER);
    send_pixel(0, 0);
    send_pixel(mbe_pkg::IMAGE_DIM - 1, mbe_pkg::IMAGE_DIM - 1);
    send_pixel(4000, 3200);
    send_pixel(mbe_pkg::IMAGE_DIM - 1, 0);
    send_pixel(0, mbe_pkg::IMAGE_DIM - 1);
    drain();
  endtask

  // Extreme register values; bit 31 of the step write must be dropped
  task automatic test_register_extremes();
    set_window(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd200);
    send_pixel(0, 0);
    send_pixel(mbe_pkg::IMAGE_DIM - 1, mbe_pkg::IMAGE_DIM - 1);
    drain();
    set_window(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    send_pixel(mbe_pkg::IMAGE_DIM - 1, mbe_pkg::IMAGE_DIM - 1);
    send_pixel(0, 0);
    send_pixel(4096, 2048);
    drain();
  endtask

  // A zero limit: no iteration at all, every point inside
  task automatic test_zero_limit();
    set_window(mbe_pkg::RE_MIN_RST, mbe_pkg::IM_MIN_RST, 32'(mbe_pkg::PIXEL_STEP_RST),
               32'hABCD_0000);
    send_pixel(4000, 3200);
    send_pixel(0, mbe_pkg::IMAGE_DIM - 1);
    drain();
  endtask

  // c_im just at half a step on either side of the axis, then just inside below it and just outside above it
  task automatic test_imag_snap();
    set_window(32'd70000000, -32'sd50500, 32'd1000, 32'd300);
    send_pixel(0, 50);
    send_pixel(0, 51);
    drain();
    set_reg(mbe_pkg::REG_IM_MIN, -32'sd50499);
    send_pixel(0, 50);
    send_pixel(0, 51);
    drain();
  endtask

  // Largest limit: one point that never escapes, one that escapes after its first iteration
  task automatic test_long_limit();
    set_window(mbe_pkg::RE_MIN_RST, mbe_pkg::IM_MIN_RST, 32'(mbe_pkg::PIXEL_STEP_RST),
               32'd65535);
    send_pixel(4000, 3200);
    send_pixel(0, 0);
    drain();
  endtask

  task automatic test_random_pixels();
    // full default view
    set_window(mbe_pkg::RE_MIN_RST, mbe_pkg::IM_MIN_RST, 32'(mbe_pkg::PIXEL_STEP_RST),
               32'(mbe_pkg::MAX_ITER_RST));
    repeat (150) send_random(mbe_pkg::IMAGE_DIM);
    drain();
    // zoom on the boundary around the neck of the set
    set_window(32'hF333_3333, 32'd0, 32'd131072, $urandom_range(64, 400));
    repeat (150) send_random(1024);
    drain();
    // random windows, the last one with raw register values
    for (int k = 0; k < 3; k++) begin
      if (k < 2)
        set_window($urandom_range(0, 939524096) - 32'd671088640,
                   $urandom_range(0, 1073741824) - 32'd536870912,
                   $urandom_range(1, 1 << $urandom_range(6, 20)),
                   $urandom_range(2, 300));
      else
        set_window($urandom, $urandom, $urandom, $urandom_range(2, 300));
      repeat (50) send_random(1024);
      drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_register_extremes();
    test_zero_limit();
    test_imag_snap();
    test_long_limit();
    directed_pixels = pixels_sent;
    test_random_pixels();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d pixel words (%0d directed, %0d random) over %0d register writes,",
             pixels_sent, directed_pixels, pixels_sent - directed_pixels, reg_writes);
    $display("with %0d result words checked and %0d mismatches.", results_seen, errors);
    if (errors == 0 && pending_pixels.size() == 0)
      $display("mandelbrot_escape_time test passed");
    else
      $display("mandelbrot_escape_time test failed");
    $finish;
  end

endmodule
